FILE: hdl/ttfe_pkg.sv
package ttfe_pkg;

    // Default sizes of the sample path
    localparam int SAMPLE_BITS_DEF = 14;
    localparam int LOOKAHEAD_DEF   = 4;

    // Field and register widths
    localparam int LEN_W   = 13;
    localparam int RATE_W  = 27;
    localparam int COUNT_W = 12;
    localparam int INDEX_W = 12;
    localparam int HALF_W  = COUNT_W - 1;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = RATE_W;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE  = 1'd1;

    // Register reset values and block length limits
    localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST = 13'd300;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST  = 27'd1730104;
    localparam logic [LEN_W-1:0]  MIN_BLOCK        = 13'd8;
    localparam logic [LEN_W-1:0]  MAX_BLOCK        = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 12'd4095;

    // Trend classes
    localparam logic [1:0] CLASS_FLAT    = 2'd0;
    localparam logic [1:0] CLASS_RISING  = 2'd1;
    localparam logic [1:0] CLASS_FALLING = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_sample;
        logic start_period;
        logic start_freq;
        logic publish;
    } ttfe_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_sample;
        logic half_zero;
        logic div_done;
        logic out_free;
    } ttfe_status_t;

endpackage

FILE: hdl/ttfe_if.sv
interface ttfe_in_if
    import ttfe_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ttfe_out_if
    import ttfe_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [RATE_W-1:0]  frequency_milli_hz;
    logic [COUNT_W-1:0] transition_count;
    logic               no_signal;

    modport source (output valid, output frequency_milli_hz, output transition_count,
                    output no_signal, input ready);
    modport sink   (input valid, input frequency_milli_hz, input transition_count,
                    input no_signal, output ready);
endinterface

FILE: hdl/ttfe_div.sv
module ttfe_div
    import ttfe_pkg::*;
#(
    parameter int DIVIDEND_W = RATE_W,
    parameter int DIVISOR_W  = LEN_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIVIDEND_W);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try the subtract
    always_comb
    begin
        shifted = {rem_reg, quot_reg[DIVIDEND_W-1]};
        fits    = shifted >= {1'b0, divisor_reg};
        diff    = shifted - {1'b0, divisor_reg};
    end

    // Count the steps and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= STEPS;
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Shift quotient bits in where the dividend bits leave
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
            rem_reg  <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: hdl/ttfe_ctrl.sv
module ttfe_ctrl
    import ttfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ttfe_status_t status,
    output ttfe_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LAUNCH  = 3'd1;
    localparam logic [2:0] ST_PERIOD  = 3'd2;
    localparam logic [2:0] ST_FREQ    = 3'd3;
    localparam logic [2:0] ST_PUBLISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Sequence sample intake, the two divisions at block end (skipped with no signal) and the publish
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_sample = 1'b1;
                    if (status.last_sample)
                        state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                if (status.half_zero)
                    state_next = ST_PUBLISH;
                else
                begin
                    cmd.start_period = 1'b1;
                    state_next       = ST_PERIOD;
                end
            end
            ST_PERIOD:
            begin
                if (status.div_done)
                begin
                    cmd.start_freq = 1'b1;
                    state_next     = ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                if (status.div_done)
                    state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

FILE: hdl/ttfe_dp.sv
module ttfe_dp
    import ttfe_pkg::*;
#(
    parameter int LOOKAHEAD   = LOOKAHEAD_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  ttfe_cmd_t              cmd,
    output ttfe_status_t           status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [RATE_W-1:0]      frequency_milli_hz,
    output logic [COUNT_W-1:0]     transition_count,
    output logic                   no_signal
);

    localparam logic [INDEX_W-1:0] LOOK_IDX = INDEX_W'(LOOKAHEAD);

    logic [LEN_W-1:0]       block_length_reg;
    logic [RATE_W-1:0]      sample_rate_reg;

    logic [SAMPLE_BITS-1:0] window_reg [LOOKAHEAD];
    logic [1:0]             prev_class_reg;
    logic [1:0]             prev_class_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic [INDEX_W-1:0]     index_reg;
    logic [COUNT_W-1:0]     result_count_reg;

    logic                   out_valid_reg;
    logic [RATE_W-1:0]      out_freq_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_nosig_reg;

    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       index_plus;
    logic                   last_sample;
    logic                   below;
    logic                   above;
    logic [1:0]             cls;
    logic                   half_zero;

    logic                   div_start;
    logic [RATE_W-1:0]      div_a;
    logic [LEN_W-1:0]       div_b;
    logic                   div_done;
    logic [RATE_W-1:0]      div_q;
    logic [LEN_W-1:0]       period;

    // Clamp the block length into its legal range
    always_comb
    begin
        if (block_length_reg < MIN_BLOCK)
            len_eff = MIN_BLOCK;
        else if (block_length_reg > MAX_BLOCK)
            len_eff = MAX_BLOCK;
        else
            len_eff = block_length_reg;
    end

    assign index_plus  = {1'b0, index_reg} + LEN_W'(1);
    assign last_sample = index_plus >= len_eff;

    // Classify the oldest window sample against the newer ones and the new word
    always_comb
    begin
        below = (window_reg[0] < sample);
        above = (window_reg[0] > sample);
        for (int k = 1; k < LOOKAHEAD; k++)
        begin
            if (!(window_reg[0] < window_reg[k]))
                below = 1'b0;
            if (!(window_reg[0] > window_reg[k]))
                above = 1'b0;
        end
        if (below)
            cls = CLASS_RISING;
        else if (above)
            cls = CLASS_FALLING;
        else
            cls = CLASS_FLAT;
    end

    // Count flat-to-falling changes, saturating
    always_comb
    begin
        count_next      = count_reg;
        prev_class_next = prev_class_reg;
        if (index_reg >= LOOK_IDX)
        begin
            if (index_reg > LOOK_IDX && prev_class_reg == CLASS_FLAT &&
                cls == CLASS_FALLING && count_reg != COUNT_MAX)
                count_next = count_reg + COUNT_W'(1);
            prev_class_next = cls;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LENGTH_RST;
            sample_rate_reg  <= SAMPLE_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_LENGTH: block_length_reg <= cfg_data[LEN_W-1:0];
                REG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data[RATE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Advance the block state on each word taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LOOKAHEAD; k++)
                window_reg[k] <= '0;
            prev_class_reg <= CLASS_FLAT;
            count_reg      <= '0;
            index_reg      <= '0;
        end
        else if (cmd.take_sample)
        begin
            for (int k = 0; k + 1 < LOOKAHEAD; k++)
                window_reg[k] <= window_reg[k + 1];
            window_reg[LOOKAHEAD-1] <= sample;
            if (last_sample)
            begin
                prev_class_reg <= CLASS_FLAT;
                count_reg      <= '0;
                index_reg      <= '0;
            end
            else
            begin
                prev_class_reg <= prev_class_next;
                count_reg      <= count_next;
                index_reg      <= index_plus[INDEX_W-1:0];
            end
        end
    end

    // Hold the final count of the block for the divisions
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample && last_sample)
            result_count_reg <= count_next;
    end

    assign half_zero = (result_count_reg[COUNT_W-1:1] == '0);

    // Share one divider: first block length by half count, then rate by period
    assign period    = (div_q[LEN_W-1:0] == '0) ? LEN_W'(1) : div_q[LEN_W-1:0];
    assign div_start = cmd.start_period | cmd.start_freq;
    assign div_a     = cmd.start_freq ? sample_rate_reg
                                      : {{(RATE_W-LEN_W){1'b0}}, len_eff};
    assign div_b     = cmd.start_freq ? period
                                      : {{(LEN_W-HALF_W){1'b0}}, result_count_reg[COUNT_W-1:1]};

    ttfe_div #(
        .DIVIDEND_W (RATE_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Output register: load on publish, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_freq_reg  <= half_zero ? '0 : div_q;
            out_count_reg <= result_count_reg;
            out_nosig_reg <= half_zero;
        end
    end

    always_comb
    begin
        status.last_sample = last_sample;
        status.half_zero   = half_zero;
        status.div_done    = div_done;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid          = out_valid_reg;
    assign frequency_milli_hz = out_freq_reg;
    assign transition_count   = out_count_reg;
    assign no_signal          = out_nosig_reg;

endmodule

FILE: hdl/trend_transition_frequency_estimator.sv
// Frequency estimator for blocks of ADC samples. Each sample word is classified
// against the next LOOKAHEAD samples as rising, falling or flat, and every
// flat-to-falling change within a block is counted. After the last sample of a
// block one result word carries the count and the frequency in millihertz,
// sample_rate_milli_hz / (block_length / (count/2)), both quotients truncated;
// a half count of zero reports frequency 0 with no_signal set. Sample words are
// taken one per clock while a block runs. The last word of a block is followed
// by a busy phase: a state to check the count, then two passes of a shared
// 27-step restoring divider (block length by half count, then rate by period),
// then a state to load the output register, plus any wait for an earlier result
// still not taken. No division is done for a block with no signal, which goes
// from the count check straight to the output load. Write block_length and
// sample_rate_milli_hz only while the block is idle.
module trend_transition_frequency_estimator
    import ttfe_pkg::*;
#(
    parameter int LOOKAHEAD   = LOOKAHEAD_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ttfe_in_if.sink                samples,
    ttfe_out_if.source             results
);

    ttfe_cmd_t    cmd;
    ttfe_status_t status;

    ttfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ttfe_dp #(
        .LOOKAHEAD   (LOOKAHEAD),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .sample             (samples.sample),
        .cmd                (cmd),
        .status             (status),
        .out_ready          (results.ready),
        .out_valid          (results.valid),
        .frequency_milli_hz (results.frequency_milli_hz),
        .transition_count   (results.transition_count),
        .no_signal          (results.no_signal)
    );

endmodule

FILE: hdl/ttfe_checker.sv
module ttfe_checker
    import ttfe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [RATE_W-1:0]  frequency_milli_hz,
    input logic [COUNT_W-1:0] transition_count,
    input logic               no_signal
);

    // A stalled result word stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(frequency_milli_hz) &&
        $stable(transition_count) && $stable(no_signal))
        else $error("result payload changed while stalled");

    // No signal reports a zero frequency
    a_nosig_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_signal |-> frequency_milli_hz == '0)
        else $error("no_signal with nonzero frequency");

    // The no-signal flag follows the count
    a_nosig_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> no_signal == (transition_count[COUNT_W-1:1] == '0))
        else $error("no_signal disagrees with transition count");

endmodule

bind trend_transition_frequency_estimator ttfe_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (results.valid),
    .out_ready          (results.ready),
    .frequency_milli_hz (results.frequency_milli_hz),
    .transition_count   (results.transition_count),
    .no_signal          (results.no_signal)
);

FILE: sim/ttfe_frequency_monitor.sv
`timescale 1ns / 100ps

module ttfe_frequency_monitor
    import ttfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ttfe_in_if                     samples,
    ttfe_out_if                    results,
    output int                     failures,
    output int                     pending
);

    typedef struct packed {
        logic [RATE_W-1:0]  frequency_milli_hz;
        logic [COUNT_W-1:0] transition_count;
        logic               no_signal;
    } estimate_t;

    estimate_t                  estimate_q[$];

    // Shadow registers and block state
    logic [LEN_W-1:0]           len_reg;
    logic [RATE_W-1:0]          rate_reg;
    logic [SAMPLE_BITS_DEF-1:0] history [LOOKAHEAD_DEF];
    logic [1:0]                 last_trend;
    logic [COUNT_W-1:0]         fall_count;
    logic [INDEX_W-1:0]         position;

    // Clamp the programmed length to the supported range
    function automatic int unsigned block_size();
        if (len_reg < MIN_BLOCK)
            return MIN_BLOCK;
        if (len_reg > MAX_BLOCK)
            return MAX_BLOCK;
        return len_reg;
    endfunction

    // Compare the oldest held sample against the rest of the window and the new word
    function automatic logic [1:0] trend_of(input logic [SAMPLE_BITS_DEF-1:0] incoming);
        logic [SAMPLE_BITS_DEF-1:0] cand;
        logic                       below;
        logic                       above;
        cand  = history[0];
        below = incoming > cand;
        above = incoming < cand;
        for (int k = 1; k < LOOKAHEAD_DEF; k++)
        begin
            below = below && (history[k] > cand);
            above = above && (history[k] < cand);
        end
        if (below)
            return CLASS_RISING;
        if (above)
            return CLASS_FALLING;
        return CLASS_FLAT;
    endfunction

    // Advance the block by one sample word; queue an estimate at block end
    task automatic absorb(input logic [SAMPLE_BITS_DEF-1:0] incoming);
        logic [1:0]  trend;
        int unsigned eff;
        int unsigned half;
        int unsigned period;
        estimate_t   est;
        eff = block_size();
        if (position >= LOOKAHEAD_DEF)
        begin
            trend = trend_of(incoming);
            // The first classified sample of a block never counts
            if (position > LOOKAHEAD_DEF && last_trend == CLASS_FLAT &&
                trend == CLASS_FALLING && fall_count != COUNT_MAX)
                fall_count = fall_count + 1'b1;
            last_trend = trend;
        end
        for (int k = 0; k + 1 < LOOKAHEAD_DEF; k++)
            history[k] = history[k + 1];
        history[LOOKAHEAD_DEF - 1] = incoming;

        if (32'(position) + 1 >= eff)
        begin
            half                   = fall_count >> 1;
            est.transition_count   = fall_count;
            est.no_signal          = (half == 0);
            est.frequency_milli_hz = '0;
            if (half != 0)
            begin
                period = eff / half;
                if (period == 0)
                    period = 1;
                est.frequency_milli_hz = RATE_W'(rate_reg / period);
            end
            estimate_q.push_back(est);
            last_trend = CLASS_FLAT;
            fall_count = '0;
            position   = '0;
        end
        else
            position = position + 1'b1;
    endtask

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            failures++;
        end
    endtask

    // Check result words first, then follow writes and sample words
    always @(posedge clk or negedge rst_n)
    begin
        estimate_t est;
        if (!rst_n)
        begin
            len_reg    = BLOCK_LENGTH_RST;
            rate_reg   = SAMPLE_RATE_RST;
            for (int k = 0; k < LOOKAHEAD_DEF; k++)
                history[k] = '0;
            last_trend = CLASS_FLAT;
            fall_count = '0;
            position   = '0;
            estimate_q.delete();
            failures   = 0;
            pending    = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (estimate_q.size() == 0)
                begin
                    $display("%0t: unexpected result: freq %0d count %0d no_signal %0d",
                             $time, results.frequency_milli_hz, results.transition_count,
                             results.no_signal);
                    failures++;
                end
                else
                begin
                    est = estimate_q.pop_front();
                    check_field("frequency_milli_hz", est.frequency_milli_hz,
                                results.frequency_milli_hz);
                    check_field("transition_count", est.transition_count,
                                results.transition_count);
                    check_field("no_signal", est.no_signal, results.no_signal);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_BLOCK_LENGTH)
                    len_reg = cfg_data[LEN_W-1:0];
                else if (cfg_index == REG_SAMPLE_RATE)
                    rate_reg = cfg_data[RATE_W-1:0];
            end
            if (samples.valid && samples.ready)
                absorb(samples.sample);
            pending = estimate_q.size();
        end
    end

endmodule

FILE: sim/tb_trend_transition_frequency_estimator.sv
`timescale 1ns / 100ps

module tb_trend_transition_frequency_estimator;
    import ttfe_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS_DEF) - 1;

    typedef enum int {
        WAVE_NOISE,
        WAVE_FLAT,
        WAVE_TRIANGLE,
        WAVE_SAW,
        WAVE_COMB,
        WAVE_WALK
    } wave_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   failures;
    int   pending;
    int   cycle_count = 0;
    int   eff_len;
    int   items_sent;
    logic tx_eager;
    logic rx_eager;

    ttfe_in_if  samples_if ();
    ttfe_out_if results_if ();

    trend_transition_frequency_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .results   (results_if)
    );

    ttfe_frequency_monitor monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .results   (results_if),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Take result words, stalling a random number of cycles before each
    initial
    begin
        int stall;
        results_if.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = rx_eager ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            results_if.ready <= 1'b1;
            @(posedge clk);
            while (!(results_if.valid && results_if.ready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    function automatic logic [SAMPLE_BITS_DEF-1:0] to_sample(input int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return SAMPLE_BITS_DEF'(SAMPLE_MAX);
        return v[SAMPLE_BITS_DEF-1:0];
    endfunction

    // Offer one sample word after a random gap; return at the falling edge after it is taken
    task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] value);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= value;
        @(posedge clk);
        while (!(samples_if.valid && samples_if.ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off until every estimate has come out, then let the block settle
    task automatic drain();
        samples_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write both registers back to back while idle
    task automatic configure(input logic [LEN_W-1:0] len, input logic [RATE_W-1:0] rate);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BLOCK_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(negedge clk);
        cfg_index <= REG_SAMPLE_RATE;
        cfg_data  <= rate;
        @(negedge clk);
        cfg_we    <= 1'b0;
        eff_len   = (len < MIN_BLOCK) ? MIN_BLOCK : (len > MAX_BLOCK) ? MAX_BLOCK : len;
    endtask

    // Send one whole block shaped as the given waveform
    task automatic send_block(input wave_t wave);
        int base;
        int step;
        int per;
        int jitter;
        int level;
        int v;
        int ph;
        base   = $urandom_range(0, 8000);
        step   = $urandom_range(1, 400);
        per    = $urandom_range(2, 40);
        jitter = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 200);
        level  = $urandom_range(0, SAMPLE_MAX);
        for (int i = 0; i < eff_len; i++)
        begin
            ph = i % per;
            case (wave)
                WAVE_NOISE:    v = $urandom_range(0, SAMPLE_MAX);
                WAVE_FLAT:     v = base;
                WAVE_TRIANGLE: v = base + step * ((ph < per / 2) ? ph : per - ph)
                                   + int'($urandom_range(0, jitter));
                WAVE_SAW:      v = base + step * (per - 1 - ph) + int'($urandom_range(0, jitter));
                // Falling peaks on every even word, flat valleys between
                WAVE_COMB:     v = (i % 2 == 1) ? int'($urandom_range(0, jitter / 50))
                                                : SAMPLE_MAX - i;
                default:
                begin
                    level = int'(to_sample(level + int'($urandom_range(0, 2 * step)) - step));
                    v     = level;
                end
            endcase
            send_sample(to_sample(v));
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0]  len;
        logic [RATE_W-1:0] rate;
        int                phase;
        int                blocks;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_BLOCK_LENGTH;
        cfg_data          = '0;
        samples_if.valid  = 1'b0;
        samples_if.sample = '0;
        tx_eager          = 1'b0;
        rx_eager          = 1'b0;
        items_sent        = 0;
        eff_len           = BLOCK_LENGTH_RST;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero length acts as the minimum; two falling peaks at full rate
        configure('0, '1);
        for (int i = 0; i < 8; i++)
            send_sample(i == 1 ? 14'd16383 : i == 3 ? 14'd16382 : 14'd0);
        // Falling first classified sample must not count: no signal
        for (int i = 0; i < 8; i++)
            send_sample(i == 0 ? 14'd16383 : 14'd0);
        drain();
        // Length just under the minimum with a zero sample rate
        configure(13'd7, '0);
        for (int i = 0; i < 8; i++)
            send_sample(i == 1 ? 14'd16383 : i == 3 ? 14'd16382 : 14'd0);

        // Random phases of blocks under varying settings
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            drain();
            if (phase == 0)
            begin
                // One long block with the densest transitions
                configure(13'd1024, '1);
                tx_eager = 1'b1;
                rx_eager = 1'b1;
                send_block(WAVE_COMB);
                items_sent += eff_len;
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0:       len = LEN_W'($urandom_range(0, 7));
                    1:       len = MIN_BLOCK;
                    2:       len = BLOCK_LENGTH_RST;
                    3:       len = LEN_W'($urandom_range(49, 200));
                    default: len = LEN_W'($urandom_range(9, 32));
                endcase
                case ($urandom_range(0, 7))
                    0:       rate = '0;
                    1:       rate = '1;
                    2:       rate = RATE_W'(1);
                    3:       rate = SAMPLE_RATE_RST;
                    default: rate = RATE_W'($urandom_range(1, 100000000));
                endcase
                configure(len, rate);
                tx_eager = ($urandom_range(0, 3) == 0);
                rx_eager = ($urandom_range(0, 3) == 0);
                blocks   = $urandom_range(1, 6);
                for (int b = 0; b < blocks; b++)
                begin
                    send_block(wave_t'($urandom_range(0, 5)));
                    items_sent += eff_len;
                    if ($urandom_range(0, 7) == 0)
                        drain();
                end
            end
            phase++;
        end

        drain();
        repeat (56) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            if (pending != 0)
                $display("%0t: %0d estimates never came out", $time, pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/ttfe_pkg.sv
hdl/ttfe_if.sv
hdl/ttfe_div.sv
hdl/ttfe_ctrl.sv
hdl/ttfe_dp.sv
hdl/trend_transition_frequency_estimator.sv
hdl/ttfe_checker.sv
sim/ttfe_frequency_monitor.sv
sim/tb_trend_transition_frequency_estimator.sv
